// ----- rtl/core/sflm_pkg.sv -----
// Package for the substring first/last match block: sizes, register codes, shared types.
package sflm_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int MAX_TEXT    = 65536;
  localparam int COUNT_W     = $clog2(MAX_TEXT + 1);
  localparam int OFFSET_W    = 16;
  localparam int LEN_W       = 5;
  localparam int BYTE_W      = 8;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 64;

  typedef enum logic [1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PATTERN_LOW    = 2'd1,
    REG_PATTERN_HIGH   = 2'd2
  } reg_index_t;

  typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    window_t          bytes;
  } pattern_cfg_t;

endpackage

// ----- rtl/core/sflm_window_match.sv -----
// Parallel compare of the byte window against the configured pattern.
module sflm_window_match
  import sflm_pkg::*;
(
  input  window_t      window,
  input  pattern_cfg_t cfg,
  output logic         hit
);

  logic [MAX_PATTERN:0] hit_by_len;

  always_comb begin
    hit_by_len = '0;
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      hit_by_len[l] = 1'b1;
      for (int i = 0; i < l; i++) begin
        if (window[l-1-i] != cfg.bytes[i]) begin
          hit_by_len[l] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    hit = 1'b0;
    if (cfg.len >= LEN_W'(1) && cfg.len <= LEN_W'(MAX_PATTERN)) begin
      hit = hit_by_len[cfg.len];
    end
  end

endmodule

// ----- rtl/core/substring_first_last_match.sv -----
// Top level of the streaming substring search with first and last match offsets.
// An end-of-text beat passes the input register, then the result register, before its result appears.
// Throughput: one text beat per cycle unless a result waits on out_ready; the window compare finishes within the cycle.
// The input register and the result register part the two channels.
// Reset (synchronous, rst high) clears the pattern registers, the text state
// and both valid flags.
module substring_first_last_match
  import sflm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [BYTE_W-1:0]   text_byte,
  input  logic                end_of_text,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                match_found,
  output logic [OFFSET_W-1:0] first_offset,
  output logic [OFFSET_W-1:0] last_offset,
  output logic                text_overflow
);

  logic [LEN_W-1:0]  pattern_length;
  logic [DATA_W-1:0] pattern_low_bytes;
  logic [DATA_W-1:0] pattern_high_bytes;
  reg_index_t        reg_index;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign reg_index = reg_index_t'(paddr[4:3]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length     <= '0;
      pattern_low_bytes  <= '0;
      pattern_high_bytes <= '0;
    end else if (cfg_write) begin
      case (reg_index)
        REG_PATTERN_LENGTH: pattern_length     <= pwdata[LEN_W-1:0];
        REG_PATTERN_LOW:    pattern_low_bytes  <= pwdata;
        REG_PATTERN_HIGH:   pattern_high_bytes <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_PATTERN_LENGTH: prdata = {{(DATA_W-LEN_W){1'b0}}, pattern_length};
      REG_PATTERN_LOW:    prdata = pattern_low_bytes;
      REG_PATTERN_HIGH:   prdata = pattern_high_bytes;
      default:            prdata = '0;
    endcase
  end

  pattern_cfg_t cfg;
  assign cfg.len   = pattern_length;
  assign cfg.bytes = {pattern_high_bytes, pattern_low_bytes};

  // input register
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_eot;
  logic              s2_ready;
  logic              s1_advance;

  assign s2_ready   = !out_valid || out_ready;
  assign s1_advance = s1_valid && s2_ready;
  assign in_ready   = !s1_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= text_byte;
      s1_eot  <= end_of_text;
    end
  end

  // text state
  window_t             recent_bytes;
  logic [COUNT_W-1:0]  bytes_seen;
  logic                seen_match;
  logic [OFFSET_W-1:0] earliest_start;
  logic [OFFSET_W-1:0] latest_start;
  logic                overflowed;

  window_t             recent_bytes_next;
  logic [COUNT_W-1:0]  bytes_seen_next;
  logic                seen_match_next;
  logic [OFFSET_W-1:0] earliest_start_next;
  logic [OFFSET_W-1:0] latest_start_next;
  logic                overflowed_next;
  window_t             shifted;
  logic                hit;
  logic [COUNT_W-1:0]  count_inc;
  logic [COUNT_W-1:0]  start;

  assign shifted   = {recent_bytes[MAX_PATTERN-2:0], s1_byte};
  assign count_inc = bytes_seen + COUNT_W'(1);
  assign start     = count_inc - COUNT_W'(pattern_length);

  sflm_window_match u_match (
    .window (shifted),
    .cfg    (cfg),
    .hit    (hit)
  );

  always_comb begin
    recent_bytes_next   = recent_bytes;
    bytes_seen_next     = bytes_seen;
    seen_match_next     = seen_match;
    earliest_start_next = earliest_start;
    latest_start_next   = latest_start;
    overflowed_next     = overflowed;
    if (bytes_seen < COUNT_W'(MAX_TEXT)) begin
      recent_bytes_next = shifted;
      bytes_seen_next   = count_inc;
      if (hit && count_inc >= COUNT_W'(pattern_length)) begin
        if (!seen_match) begin
          earliest_start_next = start[OFFSET_W-1:0];
        end
        seen_match_next   = 1'b1;
        latest_start_next = start[OFFSET_W-1:0];
      end
    end else begin
      overflowed_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent_bytes   <= '0;
      bytes_seen     <= '0;
      seen_match     <= 1'b0;
      earliest_start <= '0;
      latest_start   <= '0;
      overflowed     <= 1'b0;
    end else if (s1_advance) begin
      if (s1_eot) begin
        recent_bytes   <= '0;
        bytes_seen     <= '0;
        seen_match     <= 1'b0;
        earliest_start <= '0;
        latest_start   <= '0;
        overflowed     <= 1'b0;
      end else begin
        recent_bytes   <= recent_bytes_next;
        bytes_seen     <= bytes_seen_next;
        seen_match     <= seen_match_next;
        earliest_start <= earliest_start_next;
        latest_start   <= latest_start_next;
        overflowed     <= overflowed_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid && s1_eot;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_eot) begin
      match_found   <= seen_match_next;
      first_offset  <= earliest_start_next;
      last_offset   <= latest_start_next;
      text_overflow <= overflowed_next;
    end
  end

endmodule

// ----- rtl/core/sflm_checker.sv -----
// Port-level checker for the substring first/last match block, with its bind.
module sflm_checker
  import sflm_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic                match_found,
  input logic [OFFSET_W-1:0] first_offset,
  input logic [OFFSET_W-1:0] last_offset,
  input logic                text_overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(match_found)
      && $stable(first_offset) && $stable(last_offset) && $stable(text_overflow))
    else $error("result beat changed while stalled");

  a_no_match_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !match_found |-> first_offset == '0 && last_offset == '0)
    else $error("offsets nonzero without a match");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && match_found |-> first_offset <= last_offset)
    else $error("first match offset after last match offset");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind substring_first_last_match sflm_checker u_sflm_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .match_found   (match_found),
  .first_offset  (first_offset),
  .last_offset   (last_offset),
  .text_overflow (text_overflow)
);

// ----- verif/substring_first_last_match_tb.sv -----
// Self-checking testbench for the streaming substring search with first and last match offsets.
`timescale 1ns / 1ps

module substring_first_last_match_tb;
  import sflm_pkg::*;

  localparam int DRAIN_CYCLES  = 4;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_BEATS  = 1950;
  localparam int SETTING_BEATS = 150;
  localparam int STEADY_FROM   = 600;
  localparam int STEADY_TO     = 900;

  localparam logic [ADDR_W-1:0] LEN_ADDR      = ADDR_W'(8 * REG_PATTERN_LENGTH);
  localparam logic [ADDR_W-1:0] LOW_ADDR      = ADDR_W'(8 * REG_PATTERN_LOW);
  localparam logic [ADDR_W-1:0] HIGH_ADDR     = ADDR_W'(8 * REG_PATTERN_HIGH);
  localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = ADDR_W'(8 * (REG_PATTERN_HIGH + 1));
  localparam logic [ADDR_W-1:0] REG_ADDRS [4] = '{LEN_ADDR, LOW_ADDR, HIGH_ADDR, UNMAPPED_ADDR};

  typedef struct packed {
    logic                hit;
    logic [OFFSET_W-1:0] first_at;
    logic [OFFSET_W-1:0] last_at;
    logic                overflow;
  } match_t;

  localparam match_t NO_MATCH = '0;

  typedef struct packed {
    bit                is_write;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [BYTE_W-1:0] text;
    logic              last;
    bit                typed;
    match_t            want;
  } step_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   text_byte = '0;
  logic                end_of_text = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                match_found;
  logic [OFFSET_W-1:0] first_offset;
  logic [OFFSET_W-1:0] last_offset;
  logic                text_overflow;

  // search state and pattern registers as the block should hold them
  logic [LEN_W-1:0]  pat_len;
  logic [DATA_W-1:0] pat_lo;
  logic [DATA_W-1:0] pat_hi;
  window_t           recent;
  int                byte_count;
  bit                found_any;
  logic [OFFSET_W-1:0] first_start;
  logic [OFFSET_W-1:0] last_start;
  bit                cut_off;

  match_t pending_matches [$];
  step_t  plan [$];
  bit     steady = 1'b0;
  int     random_beats = 0;
  int     text_beats = 0;
  int     reports_seen = 0;
  int     reg_writes = 0;
  int     mismatches = 0;

  substring_first_last_match i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .text_byte     (text_byte),
    .end_of_text   (end_of_text),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .match_found   (match_found),
    .first_offset  (first_offset),
    .last_offset   (last_offset),
    .text_overflow (text_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic step_t wr(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    step_t s = '0;
    s.is_write = 1'b1;
    s.addr     = a;
    s.data     = d;
    return s;
  endfunction

  function automatic step_t beat(logic [BYTE_W-1:0] b);
    step_t s = '0;
    s.text = b;
    return s;
  endfunction

  function automatic step_t ends(logic [BYTE_W-1:0] b, match_t want);
    step_t s = '0;
    s.text  = b;
    s.last  = 1'b1;
    s.typed = 1'b1;
    s.want  = want;
    return s;
  endfunction

  function automatic logic [BYTE_W-1:0] pat_byte(int i);
    logic [2*DATA_W-1:0] both;
    both = {pat_hi, pat_lo};
    return both[8*i +: 8];
  endfunction

  function automatic void clear_text();
    recent      = '0;
    byte_count  = 0;
    found_any   = 1'b0;
    first_start = '0;
    last_start  = '0;
    cut_off     = 1'b0;
  endfunction

  // advance the search by one byte; returns 1 when the byte closes a text
  function automatic bit scan_byte(input logic [BYTE_W-1:0] b, input logic last,
                                   output match_t res);
    int n;
    bit hit;
    res = '0;
    n = int'(pat_len);
    if (byte_count < MAX_TEXT) begin
      recent = {recent[MAX_PATTERN-2:0], b};
      byte_count++;
      if (n >= 1 && n <= MAX_PATTERN && byte_count >= n) begin
        hit = 1'b1;
        for (int i = 0; i < n; i++)
          if (recent[n-1-i] != pat_byte(i)) hit = 1'b0;
        if (hit) begin
          if (!found_any) begin
            first_start = OFFSET_W'(byte_count - n);
            found_any   = 1'b1;
          end
          last_start = OFFSET_W'(byte_count - n);
        end
      end
    end else begin
      cut_off = 1'b1;
    end
    if (!last) return 1'b0;
    res.hit      = found_any;
    res.first_at = found_any ? first_start : '0;
    res.last_at  = found_any ? last_start : '0;
    res.overflow = cut_off;
    clear_text();
    return 1'b1;
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (addr)
      LEN_ADDR:  pat_len = data[LEN_W-1:0];
      LOW_ADDR:  pat_lo  = data;
      HIGH_ADDR: pat_hi  = data;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic send_beat(input logic [BYTE_W-1:0] b, input logic last, input bit typed,
                           input match_t want);
    match_t got;
    while (!steady && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    text_byte   <= b;
    end_of_text <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    text_beats++;
    if (scan_byte(b, last, got)) pending_matches.push_back(typed ? want : got);
  endtask

  // text built mostly from pattern copies, prefixes and pattern bytes, some pure noise
  task automatic send_text(input int n);
    logic [BYTE_W-1:0] q [$];
    logic [ADDR_W-1:0] addr;
    int plen, part, cut;
    bit noise;
    plen  = (pat_len >= 1 && pat_len <= MAX_PATTERN) ? int'(pat_len) : MAX_PATTERN;
    noise = ($urandom_range(3) == 0);
    while (q.size() < n) begin
      if (noise) begin
        q.push_back(8'($urandom));
      end else begin
        case ($urandom_range(9))
          0, 1, 2: for (int k = 0; k < plen; k++) q.push_back(pat_byte(k));
          3: begin
            part = $urandom_range(1, plen);
            for (int k = 0; k < part; k++) q.push_back(pat_byte(k));
          end
          4, 5, 6: q.push_back(pat_byte($urandom_range(0, plen - 1)));
          default: q.push_back(8'($urandom));
        endcase
      end
    end
    cut = ($urandom_range(99) < 4) ? $urandom_range(0, n - 1) : -1;
    for (int k = 0; k < n; k++) begin
      if (k == cut) begin
        addr = REG_ADDRS[$urandom_range(0, 3)];
        cfg_write(addr, addr == LEN_ADDR ? DATA_W'($urandom_range(0, 2**LEN_W - 1))
                                         : {$urandom, $urandom});
      end
      steady = (random_beats >= STEADY_FROM && random_beats < STEADY_TO);
      send_beat(q[k], k == n - 1, 1'b0, NO_MATCH);
      random_beats++;
    end
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    end
  endtask

  initial begin
    match_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_matches.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected: found=%0b first=%0d last=%0d overflow=%0b",
                   $time, match_found, first_offset, last_offset, text_overflow);
        end else begin
          want = pending_matches.pop_front();
          check_field("match_found", want.hit, match_found);
          check_field("first_offset", want.first_at, first_offset);
          check_field("last_offset", want.last_at, last_offset);
          check_field("text_overflow", want.overflow, text_overflow);
        end
        reports_seen++;
      end
      out_ready <= steady || ($urandom_range(99) >= 21);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
    $display("substring_first_last_match regression: fail");
    $finish;
  end

  initial begin
    logic [2*DATA_W-1:0] pat;
    logic [DATA_W-1:0]   word;
    logic [BYTE_W-1:0]   sym_a, sym_b;
    int n, len, r, setting, phase_end;
    bit narrow;

    pat_len = '0;
    pat_lo  = '0;
    pat_hi  = '0;
    clear_text();

    plan = '{
      ends(8'h00, NO_MATCH),
      wr(LEN_ADDR, DATA_W'(3)),
      wr(LOW_ADDR, DATA_W'(24'h636261)),
      beat(8'h61), beat(8'h62), beat(8'h63), beat(8'h61), beat(8'h62),
      ends(8'h63, match_t'{1'b1, 16'd0, 16'd3, 1'b0}),
      beat(8'h61),
      ends(8'h62, NO_MATCH),
      wr(LEN_ADDR, DATA_W'(2)),
      wr(LOW_ADDR, DATA_W'(16'hFFFF)),
      wr(UNMAPPED_ADDR, '0),
      beat(8'hFF), beat(8'hFF),
      ends(8'hFF, match_t'{1'b1, 16'd0, 16'd1, 1'b0}),
      beat(8'h00), beat(8'hFF),
      wr(LOW_ADDR, DATA_W'(16'h0101)),
      beat(8'h01),
      ends(8'h01, match_t'{1'b1, 16'd2, 16'd2, 1'b0}),
      wr(LEN_ADDR, DATA_W'(2**LEN_W - 1)),
      ends(8'h01, NO_MATCH),
      wr(LEN_ADDR, DATA_W'(1)),
      ends(8'h01, match_t'{1'b1, 16'd0, 16'd0, 1'b0})
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_write) cfg_write(plan[i].addr, plan[i].data);
      else send_beat(plan[i].text, plan[i].last, plan[i].typed, plan[i].want);
    end

    setting = 0;
    while (random_beats < RANDOM_BEATS) begin
      narrow = $urandom_range(1);
      sym_a  = 8'($urandom);
      sym_b  = 8'($urandom);
      for (int i = 0; i < MAX_PATTERN; i++)
        pat[8*i +: 8] = narrow ? ($urandom_range(1) ? sym_a : sym_b) : 8'($urandom);
      r   = $urandom_range(99);
      len = (r < 6) ? 0 : (r < 12) ? $urandom_range(MAX_PATTERN + 1, 2**LEN_W - 1)
                                   : $urandom_range(1, MAX_PATTERN);
      case (setting)
        0: begin
          pat = '1;
          len = MAX_PATTERN;
        end
        1: begin
          pat = '0;
          len = MAX_PATTERN;
        end
        2: len = 0;
        3: len = 2**LEN_W - 1;
        default: ;
      endcase
      cfg_write(LOW_ADDR, pat[DATA_W-1:0]);
      cfg_write(HIGH_ADDR, pat[2*DATA_W-1:DATA_W]);
      word = {$urandom, $urandom};
      word[LEN_W-1:0] = LEN_W'(len);
      cfg_write(LEN_ADDR, word);
      phase_end = random_beats + SETTING_BEATS;
      while (random_beats < phase_end && random_beats < RANDOM_BEATS) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
        send_text(n);
        if ($urandom_range(19) == 0) drain_results();
      end
      setting++;
    end

    steady = 1'b0;
    drain_results();

    $display("Ran %0d text beats over %0d pattern settings, %0d results, %0d register writes",
             text_beats, setting, reports_seen, reg_writes);
    $display("Included lengths 0 to 31, overlapping and repeated matches, rewrites mid-text");
    if (mismatches == 0) begin
      $display("substring_first_last_match regression: pass");
    end else begin
      $display("substring_first_last_match regression: fail");
    end
    $finish;
  end

endmodule

// ----- substring_first_last_match.f -----
rtl/core/sflm_pkg.sv
rtl/core/sflm_window_match.sv
rtl/core/substring_first_last_match.sv
rtl/core/sflm_checker.sv
verif/substring_first_last_match_tb.sv
